// ----- src/dpb_pkg.sv -----
// Shared constants, configuration types and register codes for the depth back-projection block.
`default_nettype none

package dpb_pkg;

  // Default parameter values
  localparam int unsigned DPB_COORD_BITS = 12;
  localparam int unsigned DPB_FRAC_BITS  = 16;

  // Fixed field widths
  localparam int unsigned CENTRE_W    = 16;
  localparam int unsigned INV_W       = 24;
  localparam int unsigned DEPTH_W     = 16;
  localparam int unsigned FIRST_COL_W = 12;
  localparam int unsigned COLOR_W     = 8;
  localparam int unsigned RGB_W       = 3 * COLOR_W;
  localparam int unsigned XY_W        = 32;
  localparam int unsigned Z_W         = 31;

  // Fixed-point layout: reciprocals are Q0.24, centre is in 1/16 pixel
  localparam int unsigned RAW_FRAC    = 24;
  localparam int unsigned SUBPIX_BITS = 4;
  localparam int unsigned ZF_W        = DEPTH_W + INV_W;

  // Result word layout: {red, green, blue, z, y, x}
  localparam int unsigned OUT_X_LSB = 0;
  localparam int unsigned OUT_Y_LSB = XY_W;
  localparam int unsigned OUT_Z_LSB = 2 * XY_W;
  localparam int unsigned OUT_B_LSB = 2 * XY_W + Z_W;
  localparam int unsigned OUT_G_LSB = OUT_B_LSB + COLOR_W;
  localparam int unsigned OUT_R_LSB = OUT_G_LSB + COLOR_W;
  localparam int unsigned OUT_W     = 2 * XY_W + Z_W + RGB_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Buffering and pipeline depth
  localparam int unsigned MID_DEPTH = 4;
  localparam int unsigned OUT_DEPTH = 8;
  localparam int unsigned OCC_W     = $clog2(OUT_DEPTH + 1);
  localparam int unsigned LANE_LAT  = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRINCIPAL_X     = 3'd0,
    REG_PRINCIPAL_Y     = 3'd1,
    REG_INV_FOCAL_X     = 3'd2,
    REG_INV_FOCAL_Y     = 3'd3,
    REG_INV_DEPTH_SCALE = 3'd4,
    REG_MAX_DEPTH_RAW   = 3'd5,
    REG_FIRST_COLUMN    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [CENTRE_W-1:0]    principal_x;
    logic [CENTRE_W-1:0]    principal_y;
    logic [INV_W-1:0]       inv_focal_x;
    logic [INV_W-1:0]       inv_focal_y;
    logic [INV_W-1:0]       inv_depth_scale;
    logic [DEPTH_W-1:0]     max_depth_raw;
    logic [FIRST_COL_W-1:0] first_column;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    principal_x:     16'd5208,
    principal_y:     16'd4056,
    inv_focal_x:     24'd32388,
    inv_focal_y:     24'd32326,
    inv_depth_scale: 24'd9321,
    max_depth_raw:   16'd9000,
    first_column:    12'd60
  };

endpackage

`default_nettype wire

// ----- src/depth_pixel_backprojection.sv -----
// Depth pixel back-projection top level: pinhole model, pixel plus depth to a 3-D point.
// Throughput: one pixel per cycle while the work queue is not full; the point pipeline
// takes a new pixel every cycle while one is queued and the output buffer has credit.
// A kept pixel passes the work queue, six pipeline stages and the output buffer.
// Dropped pixels are taken at the same rate and produce nothing.
// Reset: asynchronous, active low; registers return to defaults, both queues empty.
`default_nettype none

module depth_pixel_backprojection
  import dpb_pkg::*;
#(
  parameter int unsigned COORD_BITS = DPB_COORD_BITS,
  parameter int unsigned FRAC_BITS  = DPB_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // configuration
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // pixel requests
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [COORD_BITS-1:0] column_i,
  input  wire logic [COORD_BITS-1:0] row_i,
  input  wire logic [DEPTH_W-1:0]    depth_raw_i,
  input  wire logic [COLOR_W-1:0]    blue_i,
  input  wire logic [COLOR_W-1:0]    green_i,
  input  wire logic [COLOR_W-1:0]    red_i,
  // point requests
  output logic                       empty,
  input  wire logic                  pop,
  output logic signed [XY_W-1:0]     point_x_o,
  output logic signed [XY_W-1:0]     point_y_o,
  output logic        [Z_W-1:0]      point_z_o,
  output logic        [COLOR_W-1:0]  out_blue_o,
  output logic        [COLOR_W-1:0]  out_green_o,
  output logic        [COLOR_W-1:0]  out_red_o
);

  localparam int unsigned IN_W = 2 * COORD_BITS + DEPTH_W + RGB_W;

  cfg_t             cfg;
  logic             q_push, q_pop, q_empty;
  logic [IN_W-1:0]  q_wdata, q_rdata;
  logic             res_push, res_pop;
  logic [OUT_W-1:0] res_wdata, res_rdata;

  // Accept and classify
  dpb_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_o       (cfg),
    .push_i      (push),
    .full_i      (full),
    .column_i    (column_i),
    .row_i       (row_i),
    .depth_raw_i (depth_raw_i),
    .blue_i      (blue_i),
    .green_i     (green_i),
    .red_i       (red_i),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // Work queue between front and back
  dpb_fifo #(
    .WIDTH (IN_W),
    .DEPTH (MID_DEPTH)
  ) u_work_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .full_o  (full),
    .empty_o (q_empty)
  );

  // Point computation
  dpb_back #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .res_push_o (res_push),
    .res_data_o (res_wdata),
    .res_pop_i  (res_pop)
  );

  // Output buffer
  assign res_pop = pop && !empty;

  dpb_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_wdata),
    .pop_i   (res_pop),
    .data_o  (res_rdata),
    .full_o  (),
    .empty_o (empty)
  );

  assign point_x_o   = $signed(res_rdata[OUT_X_LSB +: XY_W]);
  assign point_y_o   = $signed(res_rdata[OUT_Y_LSB +: XY_W]);
  assign point_z_o   = res_rdata[OUT_Z_LSB +: Z_W];
  assign out_blue_o  = res_rdata[OUT_B_LSB +: COLOR_W];
  assign out_green_o = res_rdata[OUT_G_LSB +: COLOR_W];
  assign out_red_o   = res_rdata[OUT_R_LSB +: COLOR_W];

endmodule

`default_nettype wire

// ----- src/dpb_fifo.sv -----
// Small first-in first-out buffer built from a register array.
`default_nettype none

module dpb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    count_d = count_q + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ----- src/dpb_front.sv -----
// Front end: configuration registers and the pixel keep/drop decision.
`default_nettype none

module dpb_front
  import dpb_pkg::*;
#(
  parameter int unsigned COORD_BITS = DPB_COORD_BITS
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  // configuration writes
  input  wire logic                                   cfg_valid_i,
  input  wire logic [CFG_IDX_W-1:0]                   cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]                  cfg_data_i,
  output logic                                        cfg_ready_o,
  output cfg_t                                        cfg_o,
  // incoming pixel
  input  wire logic                                   push_i,
  input  wire logic                                   full_i,
  input  wire logic [COORD_BITS-1:0]                  column_i,
  input  wire logic [COORD_BITS-1:0]                  row_i,
  input  wire logic [DEPTH_W-1:0]                     depth_raw_i,
  input  wire logic [COLOR_W-1:0]                     blue_i,
  input  wire logic [COLOR_W-1:0]                     green_i,
  input  wire logic [COLOR_W-1:0]                     red_i,
  // to the work queue
  output logic                                        q_push_o,
  output logic [2*COORD_BITS+DEPTH_W+RGB_W-1:0]       q_data_o
);

  localparam int unsigned FW = (COORD_BITS > FIRST_COL_W) ? COORD_BITS : FIRST_COL_W;
  localparam logic [FW:0]   ONE_SH = (FW + 1)'(1) << COORD_BITS;
  localparam logic [FW-1:0] CMASK  = FW'(ONE_SH - 1'b1);

  cfg_t          cfg_q, cfg_d;
  logic [FW-1:0] col_w, first_w;
  logic          keep;

  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register write decode; unknown indexes are ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_PRINCIPAL_X:     cfg_d.principal_x     = cfg_data_i[CENTRE_W-1:0];
        REG_PRINCIPAL_Y:     cfg_d.principal_y     = cfg_data_i[CENTRE_W-1:0];
        REG_INV_FOCAL_X:     cfg_d.inv_focal_x     = cfg_data_i[INV_W-1:0];
        REG_INV_FOCAL_Y:     cfg_d.inv_focal_y     = cfg_data_i[INV_W-1:0];
        REG_INV_DEPTH_SCALE: cfg_d.inv_depth_scale = cfg_data_i[INV_W-1:0];
        REG_MAX_DEPTH_RAW:   cfg_d.max_depth_raw   = cfg_data_i[DEPTH_W-1:0];
        REG_FIRST_COLUMN:    cfg_d.first_column    = cfg_data_i[FIRST_COL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Drop pixels left of the first column, without depth, or too far away
  assign col_w   = FW'(column_i);
  assign first_w = FW'(cfg_q.first_column) & CMASK;
  assign keep    = (col_w >= first_w) && (depth_raw_i != '0) &&
                   (depth_raw_i <= cfg_q.max_depth_raw);

  assign q_push_o = push_i && !full_i && keep;
  assign q_data_o = {red_i, green_i, blue_i, depth_raw_i, row_i, column_i};

endmodule

`default_nettype wire

// ----- src/dpb_lane.sv -----
// One lateral coordinate lane: offset, scale by reciprocal focal length and depth, round, saturate.
`default_nettype none

module dpb_lane
  import dpb_pkg::*;
#(
  parameter int unsigned COORD_BITS = DPB_COORD_BITS,
  parameter int unsigned FRAC_BITS  = DPB_FRAC_BITS
) (
  input  wire logic                  clk_i,
  input  wire logic [COORD_BITS-1:0] pix_i,    // stage 0
  input  wire logic [CENTRE_W-1:0]   centre_i,
  input  wire logic [INV_W-1:0]      inv_f_i,
  input  wire logic [ZF_W-1:0]       zf_i,     // exact depth, aligned with stage 2
  output logic      [XY_W-1:0]       coord_o   // stage 6
);

  localparam int unsigned MAGW  = (COORD_BITS + SUBPIX_BITS > CENTRE_W) ?
                                  COORD_BITS + SUBPIX_BITS : CENTRE_W;
  localparam int unsigned DW    = MAGW + 1;
  localparam int unsigned AW    = MAGW + INV_W;
  localparam int unsigned AL    = AW / 2;
  localparam int unsigned AH    = AW - AL;
  localparam int unsigned ZL    = ZF_W / 2;
  localparam int unsigned ZH    = ZF_W - ZL;
  localparam int unsigned LL_W  = AL + ZL;
  localparam int unsigned LH_W  = AL + ZH;
  localparam int unsigned HL_W  = AH + ZL;
  localparam int unsigned HH_W  = AH + ZH;
  localparam int unsigned SA_W  = AL + ZF_W + 1;
  localparam int unsigned SB_W  = AH + ZF_W;
  localparam int unsigned TW    = AW + ZF_W + 1;
  localparam int unsigned SHIFT = 2 * RAW_FRAC + SUBPIX_BITS - FRAC_BITS;
  localparam int unsigned QW    = TW - SHIFT;
  localparam logic [SA_W-1:0] RND     = SA_W'(1) << (SHIFT - 1);
  localparam logic [QW-1:0]   LIM_POS = QW'(33'h0_7FFF_FFFF);
  localparam logic [QW-1:0]   LIM_NEG = QW'(33'h0_8000_0000);

  // stage 0 combinational: signed offset in sixteenths of a pixel
  logic [DW-1:0]   d;
  logic            neg0;
  logic [MAGW-1:0] mag0;

  assign d    = (DW'(pix_i) << SUBPIX_BITS) - DW'(centre_i);
  assign neg0 = d[DW-1];
  assign mag0 = neg0 ? MAGW'(~d + 1'b1) : d[MAGW-1:0];

  logic [MAGW-1:0] mag1_q;
  logic [AW-1:0]   a2_q;
  logic [LL_W-1:0] pp_ll_q;
  logic [LH_W-1:0] pp_lh_q;
  logic [HL_W-1:0] pp_hl_q;
  logic [HH_W-1:0] pp_hh_q;
  logic [SA_W-1:0] sa4_q;
  logic [SB_W-1:0] sb4_q;
  logic [XY_W-1:0] r5_q;
  logic [XY_W-1:0] out6_q;
  logic [5:1]      neg_q;

  logic [AL-1:0]   a_lo;
  logic [AH-1:0]   a_hi;
  logic [ZL-1:0]   z_lo;
  logic [ZH-1:0]   z_hi;
  logic [TW-1:0]   total;
  logic [QW-1:0]   q;
  logic [QW-1:0]   lim;

  assign a_lo = a2_q[AL-1:0];
  assign a_hi = a2_q[AW-1:AL];
  assign z_lo = zf_i[ZL-1:0];
  assign z_hi = zf_i[ZF_W-1:ZL];

  // stage 5 combinational: final sum, shift and clamp of the magnitude
  assign total = TW'(sa4_q) + (TW'(sb4_q) << AL);
  assign q     = total[TW-1:SHIFT];
  assign lim   = neg_q[4] ? LIM_NEG : LIM_POS;

  always_ff @(posedge clk_i) begin
    // stage 1: offset magnitude
    mag1_q   <= mag0;
    neg_q[1] <= neg0;
    // stage 2: scale by reciprocal focal length
    a2_q     <= AW'(mag1_q) * AW'(inv_f_i);
    neg_q[2] <= neg_q[1];
    // stage 3: partial products against depth
    pp_ll_q  <= LL_W'(a_lo) * LL_W'(z_lo);
    pp_lh_q  <= LH_W'(a_lo) * LH_W'(z_hi);
    pp_hl_q  <= HL_W'(a_hi) * HL_W'(z_lo);
    pp_hh_q  <= HH_W'(a_hi) * HH_W'(z_hi);
    neg_q[3] <= neg_q[2];
    // stage 4: partial sums, rounding half up folded in
    sa4_q    <= SA_W'(pp_ll_q) + (SA_W'(pp_lh_q) << ZL) + RND;
    sb4_q    <= SB_W'(pp_hl_q) + (SB_W'(pp_hh_q) << ZL);
    neg_q[4] <= neg_q[3];
    // stage 5: saturated magnitude
    r5_q     <= (q > lim) ? lim[XY_W-1:0] : q[XY_W-1:0];
    neg_q[5] <= neg_q[4];
    // stage 6: apply sign
    out6_q   <= neg_q[5] ? XY_W'(0) - r5_q : r5_q;
  end

  assign coord_o = out6_q;

endmodule

`default_nettype wire

// ----- src/dpb_back.sv -----
// Back end: issues queued pixels into the point pipeline under output-buffer credit.
`default_nettype none

module dpb_back
  import dpb_pkg::*;
#(
  parameter int unsigned COORD_BITS = DPB_COORD_BITS,
  parameter int unsigned FRAC_BITS  = DPB_FRAC_BITS
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire cfg_t                                  cfg_i,
  // work queue head
  input  wire logic                                  q_empty_i,
  input  wire logic [2*COORD_BITS+DEPTH_W+RGB_W-1:0] q_data_i,
  output logic                                       q_pop_o,
  // to the output buffer
  output logic                                       res_push_o,
  output logic      [OUT_W-1:0]                      res_data_o,
  input  wire logic                                  res_pop_i
);

  localparam int unsigned IN_W = 2 * COORD_BITS + DEPTH_W + RGB_W;
  localparam int unsigned ZS   = RAW_FRAC - FRAC_BITS;
  localparam int unsigned ZR_W = ZF_W + 1;
  localparam logic [ZR_W-1:0] Z_MAX = ZR_W'({Z_W{1'b1}});

  logic [COORD_BITS-1:0] col, row;
  logic [DEPTH_W-1:0]    depth;
  logic [RGB_W-1:0]      rgb;

  assign col   = q_data_i[COORD_BITS-1:0];
  assign row   = q_data_i[2*COORD_BITS-1:COORD_BITS];
  assign depth = q_data_i[2*COORD_BITS+DEPTH_W-1:2*COORD_BITS];
  assign rgb   = q_data_i[IN_W-1:IN_W-RGB_W];

  // Credit: items in flight plus items buffered never exceed the buffer depth
  logic [OCC_W-1:0]    occ_q, occ_d;
  logic                issue;
  logic [LANE_LAT-1:0] v_q;

  assign issue   = !q_empty_i && (occ_q < OCC_W'(OUT_DEPTH));
  assign q_pop_o = issue;
  assign occ_d   = occ_q + OCC_W'(issue) - OCC_W'(res_pop_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      v_q   <= '0;
    end else begin
      occ_q <= occ_d;
      v_q   <= {v_q[LANE_LAT-2:0], issue};
    end
  end

  // Depth path: exact depth at stage 2, rounded at 3, clamped at 4
  logic [DEPTH_W-1:0] depth1_q;
  logic [ZF_W-1:0]    zf_q;
  logic [ZR_W-1:0]    zr_d, zr3_q;
  logic [Z_W-1:0]     z4_q, z5_q, z6_q;
  logic [RGB_W-1:0]   rgb_q [LANE_LAT];

  if (ZS == 0) begin : g_z_exact
    assign zr_d = ZR_W'(zf_q);
  end else begin : g_z_round
    assign zr_d = (ZR_W'(zf_q) + (ZR_W'(1) << (ZS - 1))) >> ZS;
  end

  always_ff @(posedge clk_i) begin
    depth1_q <= depth;
    zf_q     <= ZF_W'(depth1_q) * ZF_W'(cfg_i.inv_depth_scale);
    zr3_q    <= zr_d;
    z4_q     <= (zr3_q > Z_MAX) ? {Z_W{1'b1}} : zr3_q[Z_W-1:0];
    z5_q     <= z4_q;
    z6_q     <= z5_q;
    // colour rides along with the pipeline
    rgb_q[0] <= rgb;
    for (int i = 1; i < LANE_LAT; i++) begin
      rgb_q[i] <= rgb_q[i-1];
    end
  end

  // Lateral lanes
  logic [XY_W-1:0] x_pt, y_pt;

  dpb_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_x (
    .clk_i    (clk_i),
    .pix_i    (col),
    .centre_i (cfg_i.principal_x),
    .inv_f_i  (cfg_i.inv_focal_x),
    .zf_i     (zf_q),
    .coord_o  (x_pt)
  );

  dpb_lane #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_lane_y (
    .clk_i    (clk_i),
    .pix_i    (row),
    .centre_i (cfg_i.principal_y),
    .inv_f_i  (cfg_i.inv_focal_y),
    .zf_i     (zf_q),
    .coord_o  (y_pt)
  );

  assign res_push_o = v_q[LANE_LAT-1];
  assign res_data_o = {rgb_q[LANE_LAT-1], z6_q, y_pt, x_pt};

endmodule

`default_nettype wire

// ----- src/dpb_checker.sv -----
// Port-level checks for the depth back-projection block, bound to its top level.
`default_nettype none

module dpb_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              push,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic signed [31:0] point_x_o,
  input wire logic signed [31:0] point_y_o,
  input wire logic        [30:0] point_z_o
);

  // Both queues come up empty in reset
  a_reset_state: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not empty during reset");

  // No point can reach the output sooner than the pipeline allows after reset
  a_min_latency: assert property (@(posedge clk_i) !rst_ni |-> ##8 empty)
    else $error("result appeared faster than the pipeline latency");

  // The work queue can only fill up through an accepted pixel
  a_full_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(push && !full) |-> !$rose(full))
    else $error("full rose without an accepted pixel");

  // A waiting point holds until it is taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(point_x_o) && $stable(point_y_o) &&
                          $stable(point_z_o)))
    else $error("waiting result changed or vanished");

endmodule

bind depth_pixel_backprojection dpb_checker u_dpb_checker (.*);

`default_nettype wire
